// File: rtl/modular_arithmetic_unit_assert.svh
// Assertion macros for the modular arithmetic unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define MAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MAU_ASSERT_IMPL(lbl, ante, cons, msg)
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/mau_pkg.sv
// Shared types and constants of the modular arithmetic unit.
// No dependencies; imported by every module of the block.
package mau_pkg;

  localparam int WORD_BITS = 31;
  localparam int CNT_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_INV = 3'd4,
    CMD_EQ  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_DISPATCH,
    S_DIV,
    S_MUL,
    S_POW_CHK,
    S_POW_MUL,
    S_POW_SQR,
    S_FINISH
  } state_t;

  // request to a serial unit
  typedef struct packed {
    logic  start;
    word_t opa;
    word_t opb;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_stat_t;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_stat_t;

endpackage

// File: rtl/modular_arithmetic_unit.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   in_command, in_operand_a, in_operand_b
// out_      output     out_valid/out_stall out_value, out_is_equal, out_status
// cfg_      input      cfg_wr_en           cfg_wr_data (modulus)
//
// One item at a time. Both operands are reduced by the serial divider, 31 steps
// each; add, subtract and equals then pass S_DISPATCH and S_FINISH, multiply
// and divide (non-zero divisor) take one more serial pass. Inverse runs up to 61
// serial multiplies (30 multiplies, 31 squarings), with an S_POW_CHK pass per
// exponent bit and one more once the exponent is zero. in_stall drops when the
// result is loaded into out_value; a new item can be taken in that same cycle.
// The result register lets the next item be accepted while a result waits on
// out_stall. Reset is synchronous; the modulus resets to 1.
// Depends on mau_pkg, mau_div, mau_mulmod and modular_arithmetic_unit_assert.svh.
`include "modular_arithmetic_unit_assert.svh"
module modular_arithmetic_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_command,
  input  mau_pkg::word_t        in_operand_a,
  input  mau_pkg::word_t        in_operand_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mau_pkg::word_t        out_value,
  output logic                  out_is_equal,
  output logic                  out_status,
  input  logic                  cfg_wr_en,
  input  mau_pkg::word_t        cfg_wr_data
);
  import mau_pkg::*;

  state_t     state_r, state_nxt;
  word_t      mod_r, mod_eff;
  logic [2:0] cmd_r, cmd_nxt;
  word_t      b_r, b_nxt;
  word_t      ar_r, ar_nxt;
  word_t      br_r, br_nxt;
  word_t      e_r, e_nxt;
  word_t      acc_r, acc_nxt;
  word_t      base_r, base_nxt;
  word_t      res_val_r, res_val_nxt;
  logic       res_eq_r, res_eq_nxt;
  logic       res_st_r, res_st_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_value_r, out_value_nxt;
  logic       out_eq_r, out_eq_nxt;
  logic       out_st_r, out_st_nxt;
  logic       in_take;
  unit_req_t  div_req, mul_req;
  div_stat_t  div_st;
  mul_stat_t  mul_st;

  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    word_t room;
    room = m - y;
    return (x >= room) ? x - room : x + y;
  endfunction

  function automatic word_t sub_mod(word_t x, word_t y, word_t m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  assign mod_eff = (mod_r == '0) ? WORD_BITS'(1) : mod_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  mau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_st)
  );

  mau_mulmod u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .modulus (mod_eff),
    .stat    (mul_st)
  );

  // sequencer: next state, unit requests, working registers
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    b_nxt       = b_r;
    ar_nxt      = ar_r;
    br_nxt      = br_r;
    e_nxt       = e_r;
    acc_nxt     = acc_r;
    base_nxt    = base_r;
    res_val_nxt = res_val_r;
    res_eq_nxt  = res_eq_r;
    res_st_nxt  = res_st_r;
    div_req     = '0;
    mul_req     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          cmd_nxt     = in_command;
          b_nxt       = in_operand_b;
          div_req     = '{start: 1'b1, opa: in_operand_a, opb: mod_eff};
          state_nxt   = S_RED_A;
        end
      end
      S_RED_A: begin
        if (div_st.done) begin
          ar_nxt    = div_st.rem;
          div_req   = '{start: 1'b1, opa: b_r, opb: mod_eff};
          state_nxt = S_RED_B;
        end
      end
      S_RED_B: begin
        if (div_st.done) begin
          br_nxt    = div_st.rem;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_val_nxt = '0;
        res_eq_nxt  = 1'b0;
        res_st_nxt  = 1'b0;
        state_nxt   = S_FINISH;
        case (cmd_r)
          CMD_ADD: res_val_nxt = add_mod(ar_r, br_r, mod_eff);
          CMD_SUB: res_val_nxt = sub_mod(ar_r, br_r, mod_eff);
          CMD_MUL: begin
            mul_req   = '{start: 1'b1, opa: ar_r, opb: br_r};
            state_nxt = S_MUL;
          end
          CMD_DIV: begin
            if (b_r == '0) begin
              res_st_nxt = 1'b1;
            end else begin
              div_req   = '{start: 1'b1, opa: ar_r, opb: b_r};
              state_nxt = S_DIV;
            end
          end
          CMD_INV: begin
            e_nxt     = (mod_eff >= WORD_BITS'(2)) ? mod_eff - WORD_BITS'(2) : '0;
            acc_nxt   = (mod_eff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            base_nxt  = ar_r;
            state_nxt = S_POW_CHK;
          end
          CMD_EQ:  res_eq_nxt = (ar_r == br_r);
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_st.done) begin
          res_val_nxt = div_st.quot;
          state_nxt   = S_FINISH;
        end
      end
      S_MUL: begin
        if (mul_st.done) begin
          res_val_nxt = mul_st.prod;
          state_nxt   = S_FINISH;
        end
      end
      // square-and-multiply, exponent bits from LSB
      S_POW_CHK: begin
        if (e_r == '0) begin
          res_val_nxt = acc_r;
          state_nxt   = S_FINISH;
        end else if (e_r[0]) begin
          mul_req   = '{start: 1'b1, opa: acc_r, opb: base_r};
          state_nxt = S_POW_MUL;
        end else begin
          mul_req   = '{start: 1'b1, opa: base_r, opb: base_r};
          state_nxt = S_POW_SQR;
        end
      end
      S_POW_MUL: begin
        if (mul_st.done) begin
          acc_nxt   = mul_st.prod;
          mul_req   = '{start: 1'b1, opa: base_r, opb: base_r};
          state_nxt = S_POW_SQR;
        end
      end
      S_POW_SQR: begin
        if (mul_st.done) begin
          base_nxt  = mul_st.prod;
          e_nxt     = {1'b0, e_r[WORD_BITS-1:1]};
          state_nxt = S_POW_CHK;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_eq_nxt    = out_eq_r;
    out_st_nxt    = out_st_r;
    if (state_r == S_FINISH && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res_val_r;
      out_eq_nxt    = res_eq_r;
      out_st_nxt    = res_st_r;
    end
  end

  // control state and modulus
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= WORD_BITS'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mod_r <= cfg_wr_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    b_r         <= b_nxt;
    ar_r        <= ar_nxt;
    br_r        <= br_nxt;
    e_r         <= e_nxt;
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    res_val_r   <= res_val_nxt;
    res_eq_r    <= res_eq_nxt;
    res_st_r    <= res_st_nxt;
    out_value_r <= out_value_nxt;
    out_eq_r    <= out_eq_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_is_equal = out_eq_r;
  assign out_status   = out_st_r;

  // checks
  `MAU_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "input not stalled after take")
  `MAU_ASSERT_IMPL(a_units_exclusive, 1'b1, !(div_st.done && mul_st.done), "both units done")
  `MAU_ASSERT_IMPL(a_eq_zero_value, out_valid && out_is_equal, out_value == '0, "equal with value")
  `MAU_ASSERT_IMPL(a_err_clean, out_valid && out_status, out_value == '0 && !out_is_equal, "dirty error")

endmodule

// File: rtl/mau_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on mau_pkg.
module mau_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mau_pkg::unit_req_t req,
  output mau_pkg::div_stat_t stat
);
  import mau_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            dq_r, dq_nxt;    // dividend shifts out, quotient shifts in
  word_t            rem_r, rem_nxt;
  word_t            dvs_r, dvs_nxt;
  logic [WORD_BITS:0] trial, diff;
  logic             ge;

  // one restoring step
  always_comb begin
    trial    = {rem_r, dq_r[WORD_BITS-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = req.opa;
      rem_nxt  = '0;
      dvs_nxt  = req.opb;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      dq_nxt  = {dq_r[WORD_BITS-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(WORD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = dq_r;
  assign stat.rem  = rem_r;

endmodule

// File: rtl/mau_mulmod.sv
// Bit-serial modular multiplier, multiplier bits taken MSB first.
// Depends on mau_pkg. Operands must be below the modulus.
module mau_mulmod (
  input  logic               clk,
  input  logic               rst_n,
  input  mau_pkg::unit_req_t req,
  input  mau_pkg::word_t     modulus,
  output mau_pkg::mul_stat_t stat
);
  import mau_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            acc_r, acc_nxt;
  word_t            x_r, x_nxt;
  word_t            y_r, y_nxt;
  word_t            m_r, m_nxt;
  logic [WORD_BITS:0] dbl, dbl_red, sum, sum_red;

  // acc = 2*acc mod m, then add x mod m when the multiplier bit is set
  always_comb begin
    dbl      = {acc_r, 1'b0};
    dbl_red  = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum      = dbl_red + {1'b0, x_r};
    sum_red  = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      x_nxt    = req.opa;
      y_nxt    = req.opb;
      m_nxt    = modulus;
    end else if (busy_r) begin
      acc_nxt = y_r[WORD_BITS-1] ? sum_red[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
      y_nxt   = {y_r[WORD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(WORD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
  end

  assign stat.done = done_r;
  assign stat.prod = acc_r;

endmodule
